// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker file of the regulator block.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define DIPP_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("dipp assertion failed");

// Clocked assertion that also holds during reset.
`define DIPP_ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
		else $error("dipp assertion failed");

`endif

// ===== rtl/core/dipp_pkg.sv =====
// Package for the dual-loop incremental PI PWM regulator: widths, constants,
// register indexes and the payload and configuration structs. No dependencies.
package dipp_pkg;

	localparam int MEAS_FIELD_W   = 16;
	localparam int GAIN_W         = 16;
	localparam int DUTY_W         = 10;
	localparam int ACC_FRAC       = 16;
	localparam int ACC_INT_W      = 10;
	localparam int ACC_W          = ACC_FRAC + ACC_INT_W;
	localparam int ACC_MIN        = 50;
	localparam int ACC_MAX        = 950;
	localparam int ACC_RELOAD     = 640;
	localparam int PWM_PERIOD_DEF = 1000;
	localparam int MEAS_WIDTH_DEF = 16;
	localparam int CFG_ADDR_W     = 5;
	localparam int CFG_DATA_W     = 32;

	localparam logic [ACC_W-1:0] ACC_LO_FIX     = ACC_W'(ACC_MIN) << ACC_FRAC;
	localparam logic [ACC_W-1:0] ACC_HI_FIX     = ACC_W'(ACC_MAX) << ACC_FRAC;
	localparam logic [ACC_W-1:0] ACC_RELOAD_FIX = ACC_W'(ACC_RELOAD) << ACC_FRAC;

	localparam logic [GAIN_W-1:0] KP_CURRENT_RST = 16'd5120;
	localparam logic [GAIN_W-1:0] KI_CURRENT_RST = 16'd77;
	localparam logic [GAIN_W-1:0] KP_VOLTAGE_RST = 16'd5120;
	localparam logic [GAIN_W-1:0] KI_VOLTAGE_RST = 16'd128;

	localparam logic MODE_CURRENT = 1'b0;
	localparam logic MODE_VOLTAGE = 1'b1;

	typedef enum logic [CFG_ADDR_W-3:0] {
		REG_ENABLE           = 3'd0,
		REG_MODE             = 3'd1,
		REG_CURRENT_SETPOINT = 3'd2,
		REG_VOLTAGE_SETPOINT = 3'd3,
		REG_KP_CURRENT       = 3'd4,
		REG_KI_CURRENT       = 3'd5,
		REG_KP_VOLTAGE       = 3'd6,
		REG_KI_VOLTAGE       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [MEAS_FIELD_W-1:0] measured_current;
		logic [MEAS_FIELD_W-1:0] measured_voltage;
	} sample_t;

	typedef struct packed {
		logic [DUTY_W-1:0] duty;
		logic              timer_start;
		logic              loop_used;
	} result_t;

	typedef struct packed {
		logic                    enable;
		logic                    mode;
		logic [MEAS_FIELD_W-1:0] current_setpoint;
		logic [MEAS_FIELD_W-1:0] voltage_setpoint;
		logic [GAIN_W-1:0]       kp_current;
		logic [GAIN_W-1:0]       ki_current;
		logic [GAIN_W-1:0]       kp_voltage;
		logic [GAIN_W-1:0]       ki_voltage;
	} cfg_t;

endpackage

// ===== rtl/core/dipp_regs.sv =====
// APB-style configuration register file of the regulator.
// Depends on dipp_pkg for the register indexes and the cfg_t struct.
module dipp_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dipp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [dipp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [dipp_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	output dipp_pkg::cfg_t                  cfg
);
	import dipp_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);
	assign wr     = psel & penable & pwrite & pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable           <= 1'b0;
			cfg_q.mode             <= MODE_CURRENT;
			cfg_q.current_setpoint <= '0;
			cfg_q.voltage_setpoint <= '0;
			cfg_q.kp_current       <= KP_CURRENT_RST;
			cfg_q.ki_current       <= KI_CURRENT_RST;
			cfg_q.kp_voltage       <= KP_VOLTAGE_RST;
			cfg_q.ki_voltage       <= KI_VOLTAGE_RST;
		end else if (wr) begin
			case (idx)
				REG_ENABLE:           cfg_q.enable           <= pwdata[0];
				REG_MODE:             cfg_q.mode             <= pwdata[0];
				REG_CURRENT_SETPOINT: cfg_q.current_setpoint <= pwdata[MEAS_FIELD_W-1:0];
				REG_VOLTAGE_SETPOINT: cfg_q.voltage_setpoint <= pwdata[MEAS_FIELD_W-1:0];
				REG_KP_CURRENT:       cfg_q.kp_current       <= pwdata[GAIN_W-1:0];
				REG_KI_CURRENT:       cfg_q.ki_current       <= pwdata[GAIN_W-1:0];
				REG_KP_VOLTAGE:       cfg_q.kp_voltage       <= pwdata[GAIN_W-1:0];
				REG_KI_VOLTAGE:       cfg_q.ki_voltage       <= pwdata[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_ENABLE:           prdata = CFG_DATA_W'(cfg_q.enable);
			REG_MODE:             prdata = CFG_DATA_W'(cfg_q.mode);
			REG_CURRENT_SETPOINT: prdata = CFG_DATA_W'(cfg_q.current_setpoint);
			REG_VOLTAGE_SETPOINT: prdata = CFG_DATA_W'(cfg_q.voltage_setpoint);
			REG_KP_CURRENT:       prdata = CFG_DATA_W'(cfg_q.kp_current);
			REG_KI_CURRENT:       prdata = CFG_DATA_W'(cfg_q.ki_current);
			REG_KP_VOLTAGE:       prdata = CFG_DATA_W'(cfg_q.kp_voltage);
			REG_KI_VOLTAGE:       prdata = CFG_DATA_W'(cfg_q.ki_voltage);
			default:              prdata = '0;
		endcase
	end

endmodule

// ===== rtl/core/dual_incremental_pi_pwm.sv =====
// Top level of the dual-loop incremental PI PWM regulator: five-stage datapath.
// Depends on dipp_pkg and dipp_regs.
//
//   channel  | handshake                  | payload
//   sample   | sample_valid, sample_stall | sample_t (measured current, voltage)
//   result   | result_valid, result_stall | result_t (duty, timer_start, loop_used)
//   config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// One sample per cycle while sample_stall is low; each sample passes the stages below in order.
// Stages: sample capture, error and error change, two gain multipliers, increment
// sum, accumulate and clamp (the accumulator loop) into the output register.
// Reset is immediate; no clearing pass. A disabled tick is taken and dropped.
// A stalled result holds only the full stages behind it up to the first empty stage.
module dual_incremental_pi_pwm #(
	parameter int PWM_PERIOD = dipp_pkg::PWM_PERIOD_DEF,
	parameter int MEAS_WIDTH = dipp_pkg::MEAS_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            sample_valid,
	output logic                            sample_stall,
	input  dipp_pkg::sample_t               sample,
	output logic                            result_valid,
	input  logic                            result_stall,
	output dipp_pkg::result_t               result,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [dipp_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [dipp_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [dipp_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready
);
	import dipp_pkg::*;

	localparam int EW    = (MEAS_WIDTH < MEAS_FIELD_W) ? MEAS_WIDTH : MEAS_FIELD_W;
	localparam int ERR_W = EW + 1;
	localparam int DIF_W = EW + 2;
	localparam int PRD_W = DIF_W + GAIN_W + 1;
	localparam int INC_W = PRD_W + 1;
	localparam int SUM_W = ((INC_W > ACC_W + 1) ? INC_W : ACC_W + 1) + 1;

	localparam logic signed [SUM_W-1:0] SUM_LO = signed'(SUM_W'(ACC_LO_FIX));
	localparam logic signed [SUM_W-1:0] SUM_HI = signed'(SUM_W'(ACC_HI_FIX));
	localparam logic [DUTY_W-1:0] PERIOD_LOW = DUTY_W'(PWM_PERIOD);

	cfg_t cfg;

	dipp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	logic go1, go2, go3, go4, go5, accept;

	logic started_q;
	logic signed [ERR_W-1:0] cur_last_err_q, volt_last_err_q;
	logic [ACC_W-1:0]        cur_acc_q, volt_acc_q;

	logic              v_s1, mode_s1, tstart_s1;
	logic [EW-1:0]     meas_s1;
	logic              v_s2, mode_s2, tstart_s2;
	logic signed [ERR_W-1:0] err_s2;
	logic signed [DIF_W-1:0] dif_s2;
	logic              v_s3, mode_s3, tstart_s3;
	logic signed [PRD_W-1:0] pkp_s3, pki_s3;
	logic              v_s4, mode_s4, tstart_s4;
	logic signed [INC_W-1:0] inc_s4;
	logic              v_s5, mode_s5, tstart_s5;
	logic [ACC_INT_W-1:0] int_s5;

	logic [EW-1:0]           meas_sel, setp_s1;
	logic signed [ERR_W-1:0] err_s1, last_sel;
	logic signed [DIF_W-1:0] dif_s1;
	logic [GAIN_W-1:0]       kp_sel, ki_sel;
	logic signed [PRD_W-1:0] dif_ext, err_ext, kp_ext, ki_ext;
	logic signed [INC_W-1:0] inc_s3;
	logic [ACC_W-1:0]        acc_base, acc_new;
	logic signed [SUM_W-1:0] sum_s4, clamp_s4;

	assign go5          = !v_s5 || !result_stall;
	assign go4          = !v_s4 || go5;
	assign go3          = !v_s3 || go4;
	assign go2          = !v_s2 || go3;
	assign go1          = !v_s1 || go2;
	assign sample_stall = !go1;
	assign accept       = sample_valid && go1;

	assign meas_sel = (cfg.mode == MODE_VOLTAGE) ? sample.measured_voltage[EW-1:0]
	                                             : sample.measured_current[EW-1:0];

	assign setp_s1  = (mode_s1 == MODE_VOLTAGE) ? cfg.voltage_setpoint[EW-1:0]
	                                            : cfg.current_setpoint[EW-1:0];
	assign err_s1   = signed'({1'b0, setp_s1}) - signed'({1'b0, meas_s1});
	assign last_sel = (mode_s1 == MODE_VOLTAGE) ? volt_last_err_q : cur_last_err_q;
	assign dif_s1   = DIF_W'(err_s1) - DIF_W'(last_sel);

	assign kp_sel  = (mode_s2 == MODE_VOLTAGE) ? cfg.kp_voltage : cfg.kp_current;
	assign ki_sel  = (mode_s2 == MODE_VOLTAGE) ? cfg.ki_voltage : cfg.ki_current;
	assign dif_ext = PRD_W'(dif_s2);
	assign err_ext = PRD_W'(err_s2);
	assign kp_ext  = signed'(PRD_W'(kp_sel));
	assign ki_ext  = signed'(PRD_W'(ki_sel));

	assign inc_s3 = INC_W'(pkp_s3) + INC_W'(pki_s3);

	assign acc_base = tstart_s4 ? ACC_RELOAD_FIX
	                            : ((mode_s4 == MODE_VOLTAGE) ? volt_acc_q : cur_acc_q);
	assign sum_s4   = signed'(SUM_W'(acc_base)) + SUM_W'(inc_s4);

	always_comb begin
		if (sum_s4 > SUM_HI) begin
			clamp_s4 = SUM_HI;
		end else if (sum_s4 < SUM_LO) begin
			clamp_s4 = SUM_LO;
		end else begin
			clamp_s4 = sum_s4;
		end
	end

	assign acc_new = ACC_W'(clamp_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1            <= 1'b0;
			v_s2            <= 1'b0;
			v_s3            <= 1'b0;
			v_s4            <= 1'b0;
			v_s5            <= 1'b0;
			started_q       <= 1'b0;
			cur_last_err_q  <= '0;
			volt_last_err_q <= '0;
			cur_acc_q       <= ACC_RELOAD_FIX;
			volt_acc_q      <= ACC_RELOAD_FIX;
		end else begin
			if (go1) begin
				v_s1 <= accept && cfg.enable;
			end
			if (go2) begin
				v_s2 <= v_s1;
			end
			if (go3) begin
				v_s3 <= v_s2;
			end
			if (go4) begin
				v_s4 <= v_s3;
			end
			if (go5) begin
				v_s5 <= v_s4;
			end
			if (accept && cfg.enable) begin
				started_q <= 1'b1;
			end
			if (go2 && v_s1) begin
				if (mode_s1 == MODE_VOLTAGE) begin
					volt_last_err_q <= err_s1;
				end else begin
					cur_last_err_q <= err_s1;
				end
			end
			if (go5 && v_s4) begin
				if (mode_s4 == MODE_VOLTAGE) begin
					volt_acc_q <= acc_new;
					if (tstart_s4) begin
						cur_acc_q <= ACC_RELOAD_FIX;
					end
				end else begin
					cur_acc_q <= acc_new;
					if (tstart_s4) begin
						volt_acc_q <= ACC_RELOAD_FIX;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go1 && accept) begin
			mode_s1   <= cfg.mode;
			tstart_s1 <= !started_q;
			meas_s1   <= meas_sel;
		end
		if (go2 && v_s1) begin
			mode_s2   <= mode_s1;
			tstart_s2 <= tstart_s1;
			err_s2    <= err_s1;
			dif_s2    <= dif_s1;
		end
		if (go3 && v_s2) begin
			mode_s3   <= mode_s2;
			tstart_s3 <= tstart_s2;
			pkp_s3    <= dif_ext * kp_ext;
			pki_s3    <= err_ext * ki_ext;
		end
		if (go4 && v_s3) begin
			mode_s4   <= mode_s3;
			tstart_s4 <= tstart_s3;
			inc_s4    <= inc_s3;
		end
		if (go5 && v_s4) begin
			mode_s5   <= mode_s4;
			tstart_s5 <= tstart_s4;
			int_s5    <= acc_new[ACC_FRAC +: ACC_INT_W];
		end
	end

	assign result_valid       = v_s5;
	assign result.duty        = (mode_s5 == MODE_VOLTAGE) ? PERIOD_LOW - DUTY_W'(int_s5)
	                                                      : DUTY_W'(int_s5);
	assign result.timer_start = tstart_s5;
	assign result.loop_used   = mode_s5;

endmodule

// ===== rtl/core/dipp_checker.sv =====
// Port-level checker for the regulator top level, with its bind statement.
// Depends on dipp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module dipp_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            sample_stall,
	input logic                            result_valid,
	input logic                            result_stall,
	input dipp_pkg::result_t               result,
	input logic                            psel,
	input logic                            penable,
	input logic                            pwrite,
	input logic [dipp_pkg::CFG_ADDR_W-1:0] paddr,
	input logic [dipp_pkg::CFG_DATA_W-1:0] pwdata,
	input logic                            pready
);
	import dipp_pkg::*;

	logic mode_q, seen_start_q, cfg_wr, res_take;

	assign cfg_wr   = psel && penable && pwrite && pready;
	assign res_take = result_valid && !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= MODE_CURRENT;
			seen_start_q <= 1'b0;
		end else begin
			if (cfg_wr && (reg_idx_t'(paddr[CFG_ADDR_W-1:2]) == REG_MODE)) begin
				mode_q <= pwdata[0];
			end
			if (res_take && result.timer_start) begin
				seen_start_q <= 1'b1;
			end
		end
	end

	`DIPP_ASSERT(a_result_hold, clk, arst_n,
		result_valid && result_stall |=> result_valid && $stable(result))
	`DIPP_ASSERT(a_start_once, clk, arst_n,
		res_take && result.timer_start |-> !seen_start_q)
	`DIPP_ASSERT(a_loop_matches_mode, clk, arst_n,
		result_valid |-> result.loop_used == mode_q)
	`DIPP_ASSERT(a_current_duty_range, clk, arst_n,
		result_valid && (result.loop_used == MODE_CURRENT) |->
		result.duty >= DUTY_W'(ACC_MIN) && result.duty <= DUTY_W'(ACC_MAX))
	`DIPP_ASSERT_ALWAYS(a_reset_quiet, clk,
		!arst_n |=> !result_valid && !sample_stall)

endmodule

bind dual_incremental_pi_pwm dipp_checker u_dipp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for dual_incremental_pi_pwm: a directed table of samples and
// register writes, then random phases with bursty samples and a stalling result side.
// Depends on dipp_pkg and the regulator RTL; results checked against a fixed-point PI predictor.
module testbench;
	import dipp_pkg::*;

	localparam int TICKS_WANTED = 950;
	localparam int SETTLE_CYCLES = 10;
	localparam logic [15:0] ALL_ONES = 16'hFFFF;

	typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;
	typedef enum logic [1:0] {FLOW_FREE, FLOW_LIGHT, FLOW_HEAVY, FLOW_LONG} flow_t;

	typedef struct packed {
		row_kind_t   kind;
		reg_idx_t    idx;
		logic [15:0] value;
		sample_t     smp;
		logic        typed;
		result_t     want;
	} row_t;

	localparam row_t DIRECTED_ROWS [31] = '{
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'd0, 16'd0}, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{ALL_ONES, ALL_ONES}, 1'b0, '0},
		'{ROW_WRITE, REG_ENABLE, 16'd1, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'd0, 16'd0}, 1'b1, '{10'd640, 1'b1, MODE_CURRENT}},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'h0100, 16'h0000}, 1'b0, '0},
		'{ROW_WRITE, REG_CURRENT_SETPOINT, ALL_ONES, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'd0, 16'd0}, 1'b1, '{10'd950, 1'b0, MODE_CURRENT}},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{ALL_ONES, 16'd0}, 1'b1, '{10'd50, 1'b0, MODE_CURRENT}},
		'{ROW_WRITE, REG_MODE, 16'd1, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'd0, ALL_ONES}, 1'b1, '{10'd950, 1'b0, MODE_VOLTAGE}},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'd0, 16'd0}, 1'b1, '{10'd50, 1'b0, MODE_VOLTAGE}},
		'{ROW_WRITE, REG_ENABLE, 16'd0, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{ALL_ONES, 16'h1234}, 1'b0, '0},
		'{ROW_WRITE, REG_ENABLE, 16'd1, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'd0, 16'd0}, 1'b1, '{10'd50, 1'b0, MODE_VOLTAGE}},
		'{ROW_WRITE, REG_KP_VOLTAGE, 16'd0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_KI_VOLTAGE, 16'd0, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{ALL_ONES, ALL_ONES}, 1'b1, '{10'd50, 1'b0, MODE_VOLTAGE}},
		'{ROW_WRITE, REG_KI_VOLTAGE, ALL_ONES, '0, 1'b0, '0},
		'{ROW_WRITE, REG_VOLTAGE_SETPOINT, 16'h8000, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'h5555, 16'h8001}, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'hAAAA, 16'h7FFF}, 1'b0, '0},
		'{ROW_WRITE, REG_MODE, 16'd0, '0, 1'b0, '0},
		'{ROW_WRITE, REG_KP_CURRENT, ALL_ONES, '0, 1'b0, '0},
		'{ROW_WRITE, REG_KI_CURRENT, 16'd0, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{ALL_ONES, 16'd0}, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'hFFFE, 16'd0}, 1'b0, '0},
		'{ROW_WRITE, REG_KP_CURRENT, 16'h0100, '0, 1'b0, '0},
		'{ROW_WRITE, REG_KI_CURRENT, 16'h0004, '0, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'hFF00, 16'h00FF}, 1'b0, '0},
		'{ROW_TICK,  REG_ENABLE, 16'd0, '{16'hFFF0, ALL_ONES}, 1'b0, '0}
	};

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  sample_valid = 1'b0;
	logic                  sample_stall;
	sample_t               sample = '0;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	result_t               result;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;

	cfg_t                       loop_cfg;
	logic                       started;
	logic signed [MEAS_FIELD_W:0] current_err, voltage_err;
	logic [ACC_W-1:0]           current_acc, voltage_acc;
	result_t                    duty_due [$];

	int mismatches = 0;
	int ticks_sent = 0;
	int results_due = 0;
	int results_checked = 0;
	int writes_done = 0;
	int burst_left = 0;

	flow_t flow = FLOW_FREE;
	int    flow_left = 0;
	int    hold_left = 0;

	dual_incremental_pi_pwm dut (.*);

	always #5 clk = ~clk;

	function automatic logic [ACC_INT_W-1:0] pi_velocity_step(
		input logic [MEAS_FIELD_W-1:0]       target,
		input logic [MEAS_FIELD_W-1:0]       meas,
		input logic [GAIN_W-1:0]             kp,
		input logic [GAIN_W-1:0]             ki,
		inout logic signed [MEAS_FIELD_W:0] last_err,
		inout logic [ACC_W-1:0]              acc
	);
		longint err, next_acc;
		err = longint'(target) - longint'(meas);
		next_acc = longint'(acc) + (err - longint'(last_err)) * longint'(kp)
			+ err * longint'(ki);
		if (next_acc > longint'(ACC_HI_FIX))
			next_acc = longint'(ACC_HI_FIX);
		if (next_acc < longint'(ACC_LO_FIX))
			next_acc = longint'(ACC_LO_FIX);
		last_err = (MEAS_FIELD_W + 1)'(err);
		acc = ACC_W'(next_acc);
		return acc[ACC_W-1:ACC_FRAC];
	endfunction

	function automatic bit regulate(input sample_t s, output result_t r);
		logic [ACC_INT_W-1:0] level;
		r = '0;
		if (!loop_cfg.enable)
			return 1'b0;
		if (!started) begin
			current_acc = ACC_RELOAD_FIX;
			voltage_acc = ACC_RELOAD_FIX;
			started = 1'b1;
			r.timer_start = 1'b1;
		end
		r.loop_used = loop_cfg.mode;
		if (loop_cfg.mode == MODE_CURRENT) begin
			level = pi_velocity_step(loop_cfg.current_setpoint, s.measured_current,
				loop_cfg.kp_current, loop_cfg.ki_current, current_err, current_acc);
			r.duty = DUTY_W'(level);
		end else begin
			level = pi_velocity_step(loop_cfg.voltage_setpoint, s.measured_voltage,
				loop_cfg.kp_voltage, loop_cfg.ki_voltage, voltage_err, voltage_acc);
			r.duty = DUTY_W'(PWM_PERIOD_DEF - int'(level));
		end
		return 1'b1;
	endfunction

	function automatic logic [15:0] pick_level();
		case ($urandom_range(0, 5))
			0: return 16'd0;
			1: return ALL_ONES;
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [15:0] pick_gain();
		case ($urandom_range(0, 9))
			0: return 16'd0;
			1: return ALL_ONES;
			2: return 16'($urandom());
			default: return 16'($urandom_range(0, 1536));
		endcase
	endfunction

	function automatic logic [15:0] near(input logic [15:0] target);
		int offset;
		if ($urandom_range(0, 4) == 0)
			return 16'($urandom());
		offset = int'($urandom_range(0, 1023)) - 512;
		return 16'(int'(target) + offset);
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		results_checked++;
		if (duty_due.size() == 0) begin
			report_mismatch($sformatf("result with nothing outstanding, duty %0d", got.duty));
			return;
		end
		want = duty_due.pop_front();
		if (got.duty !== want.duty)
			report_mismatch($sformatf("duty %0d, want %0d", got.duty, want.duty));
		if (got.timer_start !== want.timer_start)
			report_mismatch($sformatf("timer_start %b, want %b",
				got.timer_start, want.timer_start));
		if (got.loop_used !== want.loop_used)
			report_mismatch($sformatf("loop_used %b, want %b", got.loop_used, want.loop_used));
	endtask

	// take results and stall on a pattern that changes style now and then
	always @(posedge clk) begin
		if (!arst_n) begin
			result_stall <= 1'b0;
		end else begin
			if (result_valid && !result_stall)
				check_result(result);
			if (flow_left == 0) begin
				flow = flow_t'($urandom_range(0, 3));
				flow_left = $urandom_range(32, 256);
			end else begin
				flow_left--;
			end
			case (flow)
				FLOW_FREE: result_stall <= 1'b0;
				FLOW_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
				FLOW_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
				FLOW_LONG: begin
					if (hold_left == 0) begin
						hold_left = $urandom_range(1, 8);
						result_stall <= !result_stall;
					end else begin
						hold_left--;
					end
				end
				default: result_stall <= 1'b0;
			endcase
		end
	end

	task automatic send_tick(input sample_t s, input logic typed, input result_t want);
		result_t r;
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				sample_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 24);
		end
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (sample_stall)
			@(posedge clk);
		burst_left--;
		ticks_sent++;
		if (regulate(s, r)) begin
			duty_due.push_back(typed ? want : r);
			results_due++;
		end
	endtask

	task automatic settle();
		sample_valid <= 1'b0;
		burst_left = 0;
		while (duty_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input reg_idx_t idx, input logic [31:0] word);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ENABLE: loop_cfg.enable = word[0];
			REG_MODE: loop_cfg.mode = word[0];
			REG_CURRENT_SETPOINT: loop_cfg.current_setpoint = word[15:0];
			REG_VOLTAGE_SETPOINT: loop_cfg.voltage_setpoint = word[15:0];
			REG_KP_CURRENT: loop_cfg.kp_current = word[15:0];
			REG_KI_CURRENT: loop_cfg.ki_current = word[15:0];
			REG_KP_VOLTAGE: loop_cfg.kp_voltage = word[15:0];
			REG_KI_VOLTAGE: loop_cfg.ki_voltage = word[15:0];
			default: ;
		endcase
		writes_done++;
	endtask

	task automatic shuffle_settings(input bit every_register);
		reg_idx_t idx;
		logic [31:0] word;
		idx = idx.first();
		do begin
			if (every_register || $urandom_range(0, 2) == 0) begin
				word = $urandom();
				case (idx)
					REG_ENABLE: word[0] = ($urandom_range(0, 6) != 0);
					REG_MODE: word[0] = 1'($urandom_range(0, 1));
					REG_CURRENT_SETPOINT, REG_VOLTAGE_SETPOINT: word[15:0] = pick_level();
					default: word[15:0] = pick_gain();
				endcase
				write_register(idx, word);
			end
			idx = idx.next();
		end while (idx != idx.first());
	endtask

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		row_t row;
		sample_t s;
		int phase;
		loop_cfg = '{enable: 1'b0, mode: MODE_CURRENT, current_setpoint: '0,
			voltage_setpoint: '0, kp_current: KP_CURRENT_RST, ki_current: KI_CURRENT_RST,
			kp_voltage: KP_VOLTAGE_RST, ki_voltage: KI_VOLTAGE_RST};
		started = 1'b0;
		current_err = '0;
		voltage_err = '0;
		current_acc = ACC_RELOAD_FIX;
		voltage_acc = ACC_RELOAD_FIX;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
			row = DIRECTED_ROWS[i];
			if (row.kind == ROW_WRITE) begin
				settle();
				write_register(row.idx, 32'(row.value));
			end else begin
				send_tick(row.smp, row.typed, row.want);
			end
		end

		phase = 0;
		while (ticks_sent < TICKS_WANTED) begin
			settle();
			shuffle_settings(phase == 0);
			repeat ($urandom_range(8, 60)) begin
				s.measured_current = near(loop_cfg.current_setpoint);
				s.measured_voltage = near(loop_cfg.voltage_setpoint);
				send_tick(s, 1'b0, '0);
			end
			phase++;
		end

		settle();
		if (duty_due.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", duty_due.size()));
		$display("Sent %0d samples over %0d random phases and %0d register writes;",
			ticks_sent, phase, writes_done);
		$display("checked %0d of %0d expected regulator results, %0d mismatches.",
			results_checked, results_due, mismatches);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
